// ----- design/sps_pkg.sv -----
// Package for the Sugeno pixel similarity score: types, register codes, reset values, order table.
package sps_pkg;

  // Register and score widths are fixed by the port definition
  localparam int unsigned REG_W   = 17;
  localparam int unsigned SCORE_W = 17;
  localparam int unsigned PIX_W   = 8;

  typedef logic [REG_W-1:0] dens_t;
  typedef logic [PIX_W-1:0] pix_t;

  // Configuration register indexes
  localparam logic [1:0] REG_DENSITY_TEXTURE = 2'd0;
  localparam logic [1:0] REG_DENSITY_COLOR_A = 2'd1;
  localparam logic [1:0] REG_DENSITY_COLOR_B = 2'd2;

  // Reset values of the densities, Q1.16
  localparam dens_t RST_DENSITY_TEXTURE = 17'd21845;
  localparam dens_t RST_DENSITY_COLOR_A = 17'd21845;
  localparam dens_t RST_DENSITY_COLOR_B = 17'd21846;

  // Feature index, also the lane number
  typedef enum logic [1:0] {
    FEAT_TEXTURE = 2'd0,
    FEAT_COLOR_A = 2'd1,
    FEAT_COLOR_B = 2'd2
  } feat_t;

  // Descending order of the three similarities; element 0 is the largest
  typedef feat_t [2:0] order_t;

  // Pattern bit 2: h0>=h1, bit 1: h0>=h2, bit 0: h1>=h2.
  // Impossible patterns fall back to texture, color a, color b.
  function automatic order_t order_of(input logic [2:0] pattern);
    order_t o;
    unique case (pattern)
      3'd0: begin o[0] = FEAT_COLOR_B; o[1] = FEAT_COLOR_A; o[2] = FEAT_TEXTURE; end
      3'd1: begin o[0] = FEAT_COLOR_A; o[1] = FEAT_COLOR_B; o[2] = FEAT_TEXTURE; end
      3'd3: begin o[0] = FEAT_COLOR_A; o[1] = FEAT_TEXTURE; o[2] = FEAT_COLOR_B; end
      3'd4: begin o[0] = FEAT_COLOR_B; o[1] = FEAT_TEXTURE; o[2] = FEAT_COLOR_A; end
      3'd6: begin o[0] = FEAT_TEXTURE; o[1] = FEAT_COLOR_B; o[2] = FEAT_COLOR_A; end
      default: begin o[0] = FEAT_TEXTURE; o[1] = FEAT_COLOR_A; o[2] = FEAT_COLOR_B; end
    endcase
    return o;
  endfunction

endpackage

// ----- design/sps_ratio_lane.sv -----
// One similarity lane: min/max ratio by a pipelined restoring divider, one quotient bit per stage.
module sps_ratio_lane #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  sps_pkg::pix_t          x,
  input  sps_pkg::pix_t          y,
  output logic [FRACTION_BITS:0] h
);

  localparam int FB = FRACTION_BITS;
  localparam logic [FB:0] ONE_V = {1'b1, {FB{1'b0}}};

  // One restoring step: {quotient bit, new remainder}; remainder stays below divisor when it enters below it
  function automatic logic [8:0] div_step(input sps_pkg::pix_t rem, input sps_pkg::pix_t dv);
    logic [8:0] r2;
    logic [8:0] d;
    r2 = {rem, 1'b0};
    d  = {1'b0, dv};
    if (r2 >= d) begin
      return {1'b1, 8'(r2 - d)};
    end
    return {1'b0, r2[7:0]};
  endfunction

  sps_pkg::pix_t lo, hi;
  logic          eq;

  sps_pkg::pix_t   rem_r [FB];
  sps_pkg::pix_t   dv_r  [FB];
  logic [FB-1:0]   q_r   [FB];
  logic            eq_r  [FB];

  // Operand order; equal operands give exactly one
  always_comb begin
    eq = (x == y);
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
  end

  for (genvar s = 0; s < FB; s++) begin : g_stage
    logic [8:0] step;
    if (s == 0) begin : g_first
      assign step = div_step(lo, hi);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= step[7:0];
          dv_r[s]  <= hi;
          q_r[s]   <= {{(FB-1){1'b0}}, step[8]};
          eq_r[s]  <= eq;
        end
      end
    end else begin : g_next
      assign step = div_step(rem_r[s-1], dv_r[s-1]);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= step[7:0];
          dv_r[s]  <= dv_r[s-1];
          q_r[s]   <= {q_r[s-1][FB-2:0], step[8]};
          eq_r[s]  <= eq_r[s-1];
        end
      end
    end
  end

  assign h = eq_r[FB-1] ? ONE_V : {1'b0, q_r[FB-1]};

endmodule

// ----- design/sps_merge.sv -----
// Merge stage: sorts the lane similarities, accumulates densities, forms the Sugeno maximum.
module sps_merge #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [2:0][FRACTION_BITS:0] h,
  input  sps_pkg::dens_t [2:0]         dens,
  output logic [sps_pkg::SCORE_W-1:0]  score
);

  localparam int VW = FRACTION_BITS + 1;
  localparam int GW = (VW > int'(sps_pkg::REG_W)) ? VW : int'(sps_pkg::REG_W);
  localparam logic [VW-1:0] ONE_V = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [GW-1:0] ONE_G = GW'(ONE_V);

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum > {1'b0, ONE_V}) ? ONE_V : sum[VW-1:0];
  endfunction

  logic [2:0][VW-1:0] g;
  logic [2:0][VW-1:0] hs, gs, cum;
  logic [2:0]         pattern;
  sps_pkg::order_t    ord;

  logic [2:0][VW-1:0] hs_r, cum_r;
  logic [VW-1:0]      best_r, best_nxt;
  logic [2:0][VW-1:0] term;

  // Densities clamped to one; the clamped value always fits VW bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [GW-1:0] d;
      d    = GW'(dens[i]);
      d    = (d > ONE_G) ? ONE_G : d;
      g[i] = d[VW-1:0];
    end
  end

  // Sort and cumulative densities
  always_comb begin
    pattern = {h[0] >= h[1], h[0] >= h[2], h[1] >= h[2]};
    ord     = sps_pkg::order_of(pattern);
    for (int k = 0; k < 3; k++) begin
      unique case (ord[k])
        sps_pkg::FEAT_TEXTURE: begin hs[k] = h[0]; gs[k] = g[0]; end
        sps_pkg::FEAT_COLOR_A: begin hs[k] = h[1]; gs[k] = g[1]; end
        default:               begin hs[k] = h[2]; gs[k] = g[2]; end
      endcase
    end
    cum[0] = gs[0];
    cum[1] = sat_add(cum[0], gs[1]);
    cum[2] = sat_add(cum[1], gs[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hs_r  <= hs;
      cum_r <= cum;
    end
  end

  // Max over min(h_k, cum_k)
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term[k] = (hs_r[k] < cum_r[k]) ? hs_r[k] : cum_r[k];
    end
    best_nxt = term[0];
    if (term[1] > best_nxt) begin
      best_nxt = term[1];
    end
    if (term[2] > best_nxt) begin
      best_nxt = term[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      best_r <= best_nxt;
    end
  end

  // Score port is fixed width: truncate or zero extend
  if (VW >= int'(sps_pkg::SCORE_W)) begin : g_trunc
    assign score = best_r[sps_pkg::SCORE_W-1:0];
  end else begin : g_ext
    assign score = {{(int'(sps_pkg::SCORE_W) - VW){1'b0}}, best_r};
  end

endmodule

// ----- design/sugeno_pixel_similarity_score.sv -----
// Top level: density registers, three ratio lanes, merge stage, valid pipeline and output skid.
// Throughput: one pixel per cycle while the skid entry is free; the divider lanes retire one quotient bit per stage.
// Stalls: a two-entry output buffer lets one beat wait while the next still enters.
// Reset (rst_n low, synchronous): all valids clear, densities load 21845, 21845, 21846.
// No memory, so no clearing pass after reset.
module sugeno_pixel_similarity_score #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  sps_pkg::dens_t              cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sps_pkg::pix_t               in_frame_texture,
  input  sps_pkg::pix_t               in_back_texture,
  input  sps_pkg::pix_t               in_frame_color_a,
  input  sps_pkg::pix_t               in_frame_color_b,
  input  sps_pkg::pix_t               in_back_color_a,
  input  sps_pkg::pix_t               in_back_color_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sps_pkg::SCORE_W-1:0] out_score
);

  localparam int NS = FRACTION_BITS + 2;
  localparam int unsigned ONE_INT = 32'd1 << FRACTION_BITS;

  sps_pkg::dens_t [2:0] dens_r;

  logic [NS-1:0] v_r, v_nxt;
  logic          adv;
  logic [2:0][FRACTION_BITS:0] h;
  logic [sps_pkg::SCORE_W-1:0] pipe_score;

  logic                        out_valid_r, out_valid_nxt;
  logic                        skid_valid_r, skid_valid_nxt;
  logic [sps_pkg::SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [sps_pkg::SCORE_W-1:0] skid_score_r, skid_score_nxt;
  logic                        take, leaving;

  // Density registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dens_r[0] <= sps_pkg::RST_DENSITY_TEXTURE;
      dens_r[1] <= sps_pkg::RST_DENSITY_COLOR_A;
      dens_r[2] <= sps_pkg::RST_DENSITY_COLOR_B;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sps_pkg::REG_DENSITY_TEXTURE: dens_r[0] <= cfg_wdata;
        sps_pkg::REG_DENSITY_COLOR_A: dens_r[1] <= cfg_wdata;
        sps_pkg::REG_DENSITY_COLOR_B: dens_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves while the skid entry is free
  assign adv      = !skid_valid_r;
  assign in_ready = adv;

  always_comb begin
    v_nxt = adv ? {v_r[NS-2:0], in_valid} : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Lanes: texture, color a, color b
  sps_ratio_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_tex (
    .clk (clk), .en (adv), .x (in_frame_texture), .y (in_back_texture), .h (h[0])
  );
  sps_ratio_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_ca (
    .clk (clk), .en (adv), .x (in_frame_color_a), .y (in_back_color_a), .h (h[1])
  );
  sps_ratio_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_cb (
    .clk (clk), .en (adv), .x (in_frame_color_b), .y (in_back_color_b), .h (h[2])
  );

  sps_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (
    .clk   (clk),
    .en    (adv),
    .h     (h),
    .dens  (dens_r),
    .score (pipe_score)
  );

  // Output register plus skid entry
  assign take    = out_valid_r && out_ready;
  assign leaving = adv && v_r[NS-1];

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_score_nxt  = out_score_r;
    skid_valid_nxt = skid_valid_r;
    skid_score_nxt = skid_score_r;
    if (skid_valid_r) begin
      if (take) begin
        out_score_nxt  = skid_score_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (leaving) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_score_nxt = pipe_score;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_score_nxt = pipe_score;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_score_r  <= out_score_nxt;
    skid_score_r <= skid_score_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_score = out_score_r;

  // Checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_stalled_out_stays: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("output beat dropped while stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted beat did not enter the pipeline");

  a_score_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((FRACTION_BITS > 16) || (32'(out_score_r) <= ONE_INT)))
    else $error("score above one");

endmodule

// ----- test/sps_score_checker.sv -----
// Checker for the pixel similarity score: watches config, pixel and score beats and compares.
module sps_score_checker #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  sps_pkg::dens_t              cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  sps_pkg::pix_t               in_frame_texture,
  input  sps_pkg::pix_t               in_back_texture,
  input  sps_pkg::pix_t               in_frame_color_a,
  input  sps_pkg::pix_t               in_frame_color_b,
  input  sps_pkg::pix_t               in_back_color_a,
  input  sps_pkg::pix_t               in_back_color_b,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [sps_pkg::SCORE_W-1:0] out_score,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ONE = longint'(1) << FRACTION_BITS;
  localparam int MAX_REPORTS = 20;

  typedef logic [sps_pkg::SCORE_W-1:0] score_t;

  // shadow copy of the density registers
  sps_pkg::dens_t dens_texture;
  sps_pkg::dens_t dens_color_a;
  sps_pkg::dens_t dens_color_b;

  score_t expected_scores[$];
  int     errors;

  // min/max ratio of two codes, exactly one when they match
  function automatic longint unsigned similarity(sps_pkg::pix_t x, sps_pkg::pix_t y);
    longint unsigned lo, hi;
    if (x == y) return ONE;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    return (lo << FRACTION_BITS) / hi;
  endfunction

  function automatic longint unsigned clamp_one(longint unsigned v);
    return (v > ONE) ? ONE : v;
  endfunction

  // Sugeno integral over the three similarities, additive measure
  function automatic score_t sugeno_score(sps_pkg::pix_t ft, sps_pkg::pix_t bt,
                                          sps_pkg::pix_t fa, sps_pkg::pix_t fb,
                                          sps_pkg::pix_t ba, sps_pkg::pix_t bb);
    longint unsigned h[3];
    longint unsigned g[3];
    longint unsigned acc, term, best;
    logic [2:0]      pat;
    sps_pkg::feat_t  rank[3];
    h[sps_pkg::FEAT_TEXTURE] = similarity(ft, bt);
    h[sps_pkg::FEAT_COLOR_A] = similarity(fa, ba);
    h[sps_pkg::FEAT_COLOR_B] = similarity(fb, bb);
    g[sps_pkg::FEAT_TEXTURE] = clamp_one(dens_texture);
    g[sps_pkg::FEAT_COLOR_A] = clamp_one(dens_color_a);
    g[sps_pkg::FEAT_COLOR_B] = clamp_one(dens_color_b);
    pat = {h[0] >= h[1], h[0] >= h[2], h[1] >= h[2]};
    // descending rank; patterns that cannot happen keep the natural order
    case (pat)
      3'b000:  rank = '{sps_pkg::FEAT_COLOR_B, sps_pkg::FEAT_COLOR_A, sps_pkg::FEAT_TEXTURE};
      3'b001:  rank = '{sps_pkg::FEAT_COLOR_A, sps_pkg::FEAT_COLOR_B, sps_pkg::FEAT_TEXTURE};
      3'b011:  rank = '{sps_pkg::FEAT_COLOR_A, sps_pkg::FEAT_TEXTURE, sps_pkg::FEAT_COLOR_B};
      3'b100:  rank = '{sps_pkg::FEAT_COLOR_B, sps_pkg::FEAT_TEXTURE, sps_pkg::FEAT_COLOR_A};
      3'b110:  rank = '{sps_pkg::FEAT_TEXTURE, sps_pkg::FEAT_COLOR_B, sps_pkg::FEAT_COLOR_A};
      default: rank = '{sps_pkg::FEAT_TEXTURE, sps_pkg::FEAT_COLOR_A, sps_pkg::FEAT_COLOR_B};
    endcase
    acc  = 0;
    best = 0;
    for (int k = 0; k < 3; k++) begin
      acc  = clamp_one(acc + g[rank[k]]);
      term = (h[rank[k]] < acc) ? h[rank[k]] : acc;
      if (term > best) best = term;
    end
    return score_t'(best);
  endfunction

  always @(posedge clk) begin
    score_t want;
    if (!rst_n) begin
      dens_texture = sps_pkg::RST_DENSITY_TEXTURE;
      dens_color_a = sps_pkg::RST_DENSITY_COLOR_A;
      dens_color_b = sps_pkg::RST_DENSITY_COLOR_B;
      expected_scores.delete();
    end else begin
      // pixel beat: predict with the densities in force before this edge
      if (in_valid && in_ready)
        expected_scores.push_back(sugeno_score(in_frame_texture, in_back_texture,
                                               in_frame_color_a, in_frame_color_b,
                                               in_back_color_a, in_back_color_b));
      // score beat
      if (out_valid && out_ready) begin
        if (expected_scores.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t ns: unexpected score beat, expected none, actual %0d",
                     $time, out_score);
        end else begin
          want = expected_scores.pop_front();
          if (out_score !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t ns: score mismatch, expected %0d, actual %0d",
                       $time, want, out_score);
          end
        end
      end
      // register writes; an unused index is dropped
      if (cfg_wr_en) begin
        case (cfg_index)
          sps_pkg::REG_DENSITY_TEXTURE: dens_texture = cfg_wdata;
          sps_pkg::REG_DENSITY_COLOR_A: dens_color_a = cfg_wdata;
          sps_pkg::REG_DENSITY_COLOR_B: dens_color_b = cfg_wdata;
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending    <= expected_scores.size();
  end

endmodule

// ----- test/testbench.sv -----
// Top of the pixel similarity score testbench: clock, reset, pixel stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = 16;
  localparam int LATENCY     = FRAC + 2;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 112;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam sps_pkg::dens_t DENS_ONE = sps_pkg::dens_t'(1 << FRAC);
  localparam sps_pkg::dens_t DENS_MAX = '1;

  typedef struct packed {
    sps_pkg::pix_t frame_texture;
    sps_pkg::pix_t back_texture;
    sps_pkg::pix_t frame_color_a;
    sps_pkg::pix_t frame_color_b;
    sps_pkg::pix_t back_color_a;
    sps_pkg::pix_t back_color_b;
  } pixel_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [1:0]                  cfg_index;
  sps_pkg::dens_t              cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  sps_pkg::pix_t               in_frame_texture;
  sps_pkg::pix_t               in_back_texture;
  sps_pkg::pix_t               in_frame_color_a;
  sps_pkg::pix_t               in_frame_color_b;
  sps_pkg::pix_t               in_back_color_a;
  sps_pkg::pix_t               in_back_color_b;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [sps_pkg::SCORE_W-1:0] out_score;
  int                          fail_count;
  int                          pending;
  int                          pixels_sent;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sugeno_pixel_similarity_score #(.FRACTION_BITS(FRAC)) i_dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready,
    .in_frame_texture, .in_back_texture, .in_frame_color_a,
    .in_frame_color_b, .in_back_color_a, .in_back_color_b,
    .out_valid, .out_ready, .out_score
  );

  sps_score_checker #(.FRACTION_BITS(FRAC)) i_checker (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready,
    .in_frame_texture, .in_back_texture, .in_frame_color_a,
    .in_frame_color_b, .in_back_color_a, .in_back_color_b,
    .out_valid, .out_ready, .out_score,
    .fail_count, .pending
  );

  // score side stalls: modes of random length, always ready, random, long stalls
  int ready_mode;
  int mode_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_mode <= 0;
      mode_left  <= 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (mode_left[2:0] == 3'd0);
      endcase
    end
  end

  // present one pixel beat and hold it until accepted
  task automatic drive_pixel(pixel_t p);
    in_valid         <= 1'b1;
    in_frame_texture <= p.frame_texture;
    in_back_texture  <= p.back_texture;
    in_frame_color_a <= p.frame_color_a;
    in_frame_color_b <= p.frame_color_b;
    in_back_color_a  <= p.back_color_a;
    in_back_color_b  <= p.back_color_b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // one frame/background pair: equal, zero, near, extreme or free
  function automatic logic [15:0] draw_pair();
    sps_pkg::pix_t x, y, t;
    x = sps_pkg::pix_t'($urandom);
    y = sps_pkg::pix_t'($urandom);
    case ($urandom_range(0, 9))
      0, 1: y = x;
      2:    x = '0;
      3:    y = x + sps_pkg::pix_t'($urandom_range(1, 4));
      4:    begin x = '1; y = sps_pkg::pix_t'($urandom_range(0, 1)) ? '0 : y; end
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      t = x; x = y; y = t;
    end
    return {x, y};
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t     p;
    logic [15:0] pr;
    pr = draw_pair(); p.frame_texture = pr[15:8]; p.back_texture = pr[7:0];
    pr = draw_pair(); p.frame_color_a = pr[15:8]; p.back_color_a = pr[7:0];
    pr = draw_pair(); p.frame_color_b = pr[15:8]; p.back_color_b = pr[7:0];
    return p;
  endfunction

  // random pixels in bursts with gaps; some bursts run back to back
  task automatic stream_random(int count);
    int left, burst, gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) drive_pixel(random_pixel());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drain: no beat in flight, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, sps_pkg::dens_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // load all three densities, optionally with a write to the unused index
  task automatic program_densities(sps_pkg::dens_t t, sps_pkg::dens_t a,
                                   sps_pkg::dens_t b, bit stray);
    write_reg(sps_pkg::REG_DENSITY_TEXTURE, t);
    write_reg(sps_pkg::REG_DENSITY_COLOR_A, a);
    write_reg(sps_pkg::REG_DENSITY_COLOR_B, b);
    if (stray) write_reg(REG_UNUSED, sps_pkg::dens_t'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= sps_pkg::REG_DENSITY_TEXTURE;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_frame_texture <= '0;
    in_back_texture  <= '0;
    in_frame_color_a <= '0;
    in_frame_color_b <= '0;
    in_back_color_a  <= '0;
    in_back_color_b  <= '0;
    pixels_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels under the reset densities
    drive_pixel(pixel_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    drive_pixel(pixel_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    drive_pixel(pixel_t'{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255});
    drive_pixel(pixel_t'{8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0});
    drive_pixel(pixel_t'{8'd1, 8'd255, 8'd254, 8'd1, 8'd255, 8'd255});
    drive_pixel(pixel_t'{8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd1});
    // every descending order of the three similarities
    drive_pixel(pixel_t'{8'd200, 8'd200, 8'd128, 8'd10, 8'd255, 8'd255});
    drive_pixel(pixel_t'{8'd200, 8'd200, 8'd10, 8'd128, 8'd255, 8'd255});
    drive_pixel(pixel_t'{8'd128, 8'd255, 8'd200, 8'd10, 8'd200, 8'd255});
    drive_pixel(pixel_t'{8'd10, 8'd255, 8'd200, 8'd128, 8'd200, 8'd255});
    drive_pixel(pixel_t'{8'd128, 8'd255, 8'd10, 8'd200, 8'd255, 8'd200});
    drive_pixel(pixel_t'{8'd10, 8'd255, 8'd128, 8'd200, 8'd255, 8'd200});
    // ties: all three equal, two equal on top, two equal at the bottom
    drive_pixel(pixel_t'{8'd1, 8'd2, 8'd64, 8'd50, 8'd128, 8'd100});
    drive_pixel(pixel_t'{8'd9, 8'd9, 8'd7, 8'd0, 8'd7, 8'd1});
    drive_pixel(pixel_t'{8'd77, 8'd77, 8'd3, 8'd3, 8'd9, 8'd9});
    drive_pixel(pixel_t'{8'd40, 8'd80, 8'd90, 8'd80, 8'd180, 8'd160});
    drive_pixel(pixel_t'{8'd254, 8'd255, 8'd170, 8'd85, 8'd85, 8'd170});
    drive_pixel(pixel_t'{8'hAA, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'h55});
    wait_idle();

    // random pixels over a range of density settings
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: program_densities('0, '0, '0, 1'b0);
        1: program_densities(DENS_ONE, DENS_ONE, DENS_ONE, 1'b0);
        2: program_densities(DENS_MAX, DENS_MAX, DENS_MAX, 1'b1);
        3: program_densities(DENS_ONE, '0, '0, 1'b0);
        4: program_densities('0, '0, DENS_ONE, 1'b1);
        5: program_densities(sps_pkg::dens_t'($urandom_range(0, 1 << FRAC)),
                             sps_pkg::dens_t'($urandom_range(0, 1 << FRAC)),
                             sps_pkg::dens_t'($urandom_range(0, 1 << FRAC)), 1'b0);
        6: program_densities(sps_pkg::dens_t'($urandom_range(0, 1 << (FRAC - 1))),
                             sps_pkg::dens_t'($urandom_range(0, 1 << (FRAC - 1))),
                             sps_pkg::dens_t'($urandom_range(0, 1 << (FRAC - 1))), 1'b0);
        default: program_densities(sps_pkg::dens_t'($urandom), sps_pkg::dens_t'($urandom),
                                   sps_pkg::dens_t'($urandom), 1'b1);
      endcase
      stream_random(PHASE_ITEMS);
      wait_idle();
    end

    $display("Scored %0d pixels under the reset densities and %0d programmed settings,",
             pixels_sent, NUM_PHASES);
    $display("including zero, one and over-range densities and every similarity order.");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
design/sps_pkg.sv
design/sps_ratio_lane.sv
design/sps_merge.sv
design/sugeno_pixel_similarity_score.sv
test/sps_score_checker.sv
test/testbench.sv
